FILE: hw/rtl/blake2b_hash_engine_assert.svh
// Assertion macros for the BLAKE2b hash engine checker.
// No dependencies.
`ifndef BLAKE2B_HASH_ENGINE_ASSERT_SVH
`define BLAKE2B_HASH_ENGINE_ASSERT_SVH
`define B2B_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define B2B_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/b2b_pkg.sv
// Constants and helpers for the BLAKE2b hash engine.
// No dependencies.
package b2b_pkg;
    localparam int ROUND_COUNT = 12;
    localparam int BLOCK_BYTES = 128;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

    localparam logic REG_DIGEST_LENGTH = 1'b0;
    localparam logic REG_KEY_LENGTH    = 1'b1;

    // v-vector indices a,b,c,d for each of the 8 G steps of a round
    localparam logic [3:0] GA [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd3};
    localparam logic [3:0] GB [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4};
    localparam logic [3:0] GC [8] = '{4'd8, 4'd9, 4'd10, 4'd11, 4'd10, 4'd11, 4'd8, 4'd9};
    localparam logic [3:0] GD [8] = '{4'd12, 4'd13, 4'd14, 4'd15, 4'd15, 4'd12, 4'd13, 4'd14};

    function automatic logic [6:0] eff_dlen(input logic [6:0] dl);
        logic [6:0] r;
        r = dl;
        if (dl == 7'd0) r = 7'd1;
        else if (dl > 7'd64) r = 7'd64;
        return r;
    endfunction

    function automatic logic [63:0] param_word(input logic [6:0] dl, input logic [6:0] kl);
        logic [6:0] k;
        k = (kl > 7'd64) ? 7'd64 : kl;
        return {39'd0, 1'b1, 7'd0, 1'b1, 1'b0, k, 1'b0, eff_dlen(dl)};
    endfunction
endpackage

FILE: hw/rtl/blake2b_hash_engine.sv
// BLAKE2b hash engine top level: buffer, counter, shared half-G unit, output.
// Depends on b2b_pkg.
//
// Usage: message words enter on in_valid/in_stall, digest words leave on
// out_valid/out_stall; cfg_valid/cfg_ready writes digest_length (index 0)
// or key_length (index 1), each write restarts the hash state. cfg_ready is
// high only while idle with in_valid low.
// The bytes of an accepted word enter the buffer one per cycle, except while
// a full block is compressed; in_stall stays high until the whole word is in.
// A full buffered block that meets another byte is compressed first: a check,
// a setup, the half-G steps (12 rounds x 8 G steps x 2 halves) and a fold.
// A final word appends its bytes, then runs the final compression, and
// out_valid rises (a pending full block is compressed first if the word has bytes).
// Then ceil(L/8) digest words follow, L being digest_length taken as 1 when
// 0 and as 64 above 64, one per cycle while out_stall is low. out_valid
// holds with steady data while the receiver stalls. in_stall is high for
// the whole run.
// Reset: registers return to 64-byte digest, unkeyed, chain = IV ^ param
// word, empty buffer and zero counter; no clearing pass is needed.
module blake2b_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] message_word,
    input  logic [3:0]  byte_count,
    input  logic        final_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic [3:0]  valid_bytes,
    output logic        last_of_digest
);
    localparam int FILL_W = $clog2(b2b_pkg::BLOCK_BYTES + 1);
    localparam int RND_W  = $clog2(b2b_pkg::ROUND_COUNT);

    typedef enum logic [2:0] {S_IDLE, S_APPEND, S_INIT, S_ROUND, S_FOLD, S_OUT}
        state_t;

    state_t            state_reg;
    logic [6:0]        dlen_reg, klen_reg;
    logic [63:0]       h_reg [8];
    logic [63:0]       m_reg [16];
    logic [63:0]       v_reg [16];
    logic [FILL_W-1:0] fill_reg;
    logic [127:0]      cnt_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [3:0]        sig_reg;
    logic [2:0]        g_reg;
    logic              half_reg;
    logic              fin_reg;   // current item is final
    logic              last_reg;  // compression with last flag
    logic [63:0]       word_reg;
    logic [3:0]        bcnt_reg;
    logic [2:0]        oidx_reg;

    logic [3:0]  ia, ib, ic, id, mi;
    logic [63:0] a1, d1, c1, b1, mx;
    logic [63:0] pw;
    logic [6:0]  edl;
    logic [2:0]  olast;
    logic [3:0]  bc;
    logic [FILL_W-1:0] fill_next;

    assign edl = b2b_pkg::eff_dlen(dlen_reg);
    assign pw  = b2b_pkg::param_word(dlen_reg, klen_reg);
    assign olast = 3'((edl - 7'd1) >> 3);
    assign bc = (byte_count > 4'd8) ? 4'd8 : byte_count;

    // one half of G: a+=b+m; d=ror(d^a); c+=d; b=ror(b^c)
    always_comb
    begin
        ia = b2b_pkg::GA[g_reg];
        ib = b2b_pkg::GB[g_reg];
        ic = b2b_pkg::GC[g_reg];
        id = b2b_pkg::GD[g_reg];
        mi = b2b_pkg::SIGMA[sig_reg][{g_reg, half_reg}];
        mx = m_reg[mi];
        a1 = v_reg[ia] + v_reg[ib] + mx;
        d1 = v_reg[id] ^ a1;
        d1 = half_reg ? {d1[15:0], d1[63:16]} : {d1[31:0], d1[63:32]};
        c1 = v_reg[ic] + d1;
        b1 = v_reg[ib] ^ c1;
        b1 = half_reg ? {b1[62:0], b1[63]} : {b1[23:0], b1[63:24]};
    end

    // a message word takes priority over a register write
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign digest_word = h_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign valid_bytes = (oidx_reg == olast) ? 4'(edl - {1'b0, olast, 3'd0}) : 4'd8;
    assign last_of_digest = (oidx_reg == olast);
    assign fill_next = fill_reg + FILL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dlen_reg  <= 7'd64;
            klen_reg  <= 7'd0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= (i == 0) ? (b2b_pkg::IV[0] ^ 64'h0000_0000_0101_0040)
                                     : b2b_pkg::IV[i];
            for (int i = 0; i < 16; i++)
                m_reg[i] <= '0;
            fill_reg <= '0;
            cnt_reg  <= '0;
            rnd_reg  <= '0;
            sig_reg  <= '0;
            g_reg    <= '0;
            half_reg <= 1'b0;
            fin_reg  <= 1'b0;
            last_reg <= 1'b0;
            bcnt_reg <= '0;
            oidx_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        word_reg <= message_word;
                        bcnt_reg <= bc;
                        fin_reg  <= final_word;
                        state_reg <= S_APPEND;
                    end
                    else if (cfg_valid)
                    begin
                        logic [6:0] nd, nk;
                        nd = (cfg_index == b2b_pkg::REG_DIGEST_LENGTH) ? cfg_data : dlen_reg;
                        nk = (cfg_index == b2b_pkg::REG_KEY_LENGTH) ? cfg_data : klen_reg;
                        dlen_reg <= nd;
                        klen_reg <= nk;
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= b2b_pkg::IV[i] ^
                                ((i == 0) ? b2b_pkg::param_word(nd, nk) : 64'd0);
                        for (int i = 0; i < 16; i++)
                            m_reg[i] <= '0;
                        fill_reg <= '0;
                        cnt_reg  <= '0;
                    end
                end
                S_APPEND:
                begin
                    // bytes go in one at a time; full buffer compresses first
                    if (bcnt_reg != 4'd0 && fill_reg == FILL_W'(b2b_pkg::BLOCK_BYTES))
                    begin
                        cnt_reg  <= cnt_reg + 128'(b2b_pkg::BLOCK_BYTES);
                        last_reg <= 1'b0;
                        state_reg <= S_INIT;
                    end
                    else if (bcnt_reg != 4'd0)
                    begin
                        for (int i = 0; i < 8; i++)
                            if (fill_reg[2:0] == 3'(i))
                                m_reg[fill_reg[6:3]][8*i +: 8] <= word_reg[7:0];
                        word_reg <= word_reg >> 8;
                        bcnt_reg <= bcnt_reg - 4'd1;
                        fill_reg <= fill_next;
                    end
                    else if (fin_reg)
                    begin
                        cnt_reg  <= cnt_reg + 128'(fill_reg);
                        last_reg <= 1'b1;
                        state_reg <= S_INIT;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_INIT:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i]   <= h_reg[i];
                        v_reg[i+8] <= b2b_pkg::IV[i];
                    end
                    v_reg[12] <= b2b_pkg::IV[4] ^ cnt_reg[63:0];
                    v_reg[13] <= b2b_pkg::IV[5] ^ cnt_reg[127:64];
                    v_reg[14] <= last_reg ? ~b2b_pkg::IV[6] : b2b_pkg::IV[6];
                    rnd_reg  <= '0;
                    sig_reg  <= '0;
                    g_reg    <= '0;
                    half_reg <= 1'b0;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    v_reg[ia] <= a1;
                    v_reg[ib] <= b1;
                    v_reg[ic] <= c1;
                    v_reg[id] <= d1;
                    half_reg <= ~half_reg;
                    if (half_reg)
                    begin
                        g_reg <= g_reg + 3'd1;
                        if (g_reg == 3'd7)
                        begin
                            sig_reg <= (sig_reg == 4'd9) ? 4'd0 : sig_reg + 4'd1;
                            rnd_reg <= rnd_reg + RND_W'(1);
                            if (rnd_reg == RND_W'(b2b_pkg::ROUND_COUNT - 1))
                                state_reg <= S_FOLD;
                        end
                    end
                end
                S_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i+8];
                    if (last_reg)
                    begin
                        oidx_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        for (int i = 0; i < 16; i++)
                            m_reg[i] <= '0;
                        fill_reg  <= '0;
                        state_reg <= S_APPEND;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == olast)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= b2b_pkg::IV[i] ^ ((i == 0) ? pw : 64'd0);
                            for (int i = 0; i < 16; i++)
                                m_reg[i] <= '0;
                            fill_reg  <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hw/rtl/b2b_checker.sv
// Port-level checker for the BLAKE2b hash engine, bound to the top level.
// Depends on blake2b_hash_engine_assert.svh.
`include "blake2b_hash_engine_assert.svh"
module b2b_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] word_index,
    input logic       last_of_digest,
    input logic       cfg_ready
);
    logic idx_adv;
    assign idx_adv = out_valid && !out_stall && !last_of_digest;

    `B2B_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, in_stall)
    `B2B_ASSERT_NXT(a_idx_step, clk, rst_n, idx_adv, out_valid && word_index == $past(word_index) + 3'd1)
    `B2B_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(word_index))
    `B2B_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, !in_stall)
    `B2B_ASSERT_NXT(a_in_take, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind blake2b_hash_engine b2b_checker u_b2b_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .word_index(word_index),
    .last_of_digest(last_of_digest), .cfg_ready(cfg_ready));

FILE: sim/blake2b_hash_engine_tb.sv
// Self-checking testbench for blake2b_hash_engine: directed table, then random messages.
// The digest words are predicted by a behavioral BLAKE2b model inside this file.
// Depends on b2b_pkg and the engine RTL.
`timescale 1ns / 1ps

module blake2b_hash_engine_tb;

    localparam int IDLE_WAIT = 500;   // covers one full compression plus margin

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic [3:0]  vbytes;
        logic        last;
    } digest_word_t;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        fin;
        bit          has_ref;
        logic [63:0] ref_w0;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        final_word;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic [3:0]  valid_bytes;
    logic        last_of_digest;

    blake2b_hash_engine uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .message_word(message_word),
        .byte_count(byte_count), .final_word(final_word),
        .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
        .word_index(word_index), .valid_bytes(valid_bytes),
        .last_of_digest(last_of_digest)
    );

    // model state
    logic [6:0]  cfg_dlen;
    logic [6:0]  cfg_klen;
    logic [63:0] hash_chain [8];
    logic [63:0] msg_block [16];
    logic [63:0] mix_v [16];
    int          block_fill;
    logic [63:0] byte_cnt_lo;
    logic [63:0] byte_cnt_hi;

    digest_word_t digest_q [$];
    int           err_count = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [6:0] taken_dlen();
        if (cfg_dlen == 7'd0) return 7'd1;
        if (cfg_dlen > 7'd64) return 7'd64;
        return cfg_dlen;
    endfunction

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic hash_init();
        logic [63:0] pw;
        logic [7:0]  kl;
        kl = (cfg_klen > 7'd64) ? 8'd64 : {1'b0, cfg_klen};
        pw = {56'd0, 1'b0, taken_dlen()} | ({56'd0, kl} << 8) | (64'd1 << 16) | (64'd1 << 24);
        for (int i = 0; i < 8; i++) hash_chain[i] = b2b_pkg::IV[i];
        hash_chain[0] ^= pw;
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        block_fill = 0;
        byte_cnt_lo = '0;
        byte_cnt_hi = '0;
    endtask

    task automatic mix_g(input int a, input int b, input int c, input int d,
                         input logic [63:0] x, input logic [63:0] y);
        mix_v[a] = mix_v[a] + mix_v[b] + x; mix_v[d] = ror64(mix_v[d] ^ mix_v[a], 32);
        mix_v[c] = mix_v[c] + mix_v[d];     mix_v[b] = ror64(mix_v[b] ^ mix_v[c], 24);
        mix_v[a] = mix_v[a] + mix_v[b] + y; mix_v[d] = ror64(mix_v[d] ^ mix_v[a], 16);
        mix_v[c] = mix_v[c] + mix_v[d];     mix_v[b] = ror64(mix_v[b] ^ mix_v[c], 63);
    endtask

    task automatic add_count(input logic [63:0] amount);
        byte_cnt_lo = byte_cnt_lo + amount;
        if (byte_cnt_lo < amount) byte_cnt_hi = byte_cnt_hi + 1;
    endtask

    task automatic compress(input bit last_block);
        logic [3:0] sg [16];
        for (int i = 0; i < 8; i++) begin
            mix_v[i] = hash_chain[i];
            mix_v[i + 8] = b2b_pkg::IV[i];
        end
        mix_v[12] ^= byte_cnt_lo;
        mix_v[13] ^= byte_cnt_hi;
        if (last_block) mix_v[14] = ~mix_v[14];
        for (int r = 0; r < b2b_pkg::ROUND_COUNT; r++) begin
            for (int j = 0; j < 16; j++) sg[j] = b2b_pkg::SIGMA[r % 10][j];
            mix_g(0, 4,  8, 12, msg_block[sg[0]],  msg_block[sg[1]]);
            mix_g(1, 5,  9, 13, msg_block[sg[2]],  msg_block[sg[3]]);
            mix_g(2, 6, 10, 14, msg_block[sg[4]],  msg_block[sg[5]]);
            mix_g(3, 7, 11, 15, msg_block[sg[6]],  msg_block[sg[7]]);
            mix_g(0, 5, 10, 15, msg_block[sg[8]],  msg_block[sg[9]]);
            mix_g(1, 6, 11, 12, msg_block[sg[10]], msg_block[sg[11]]);
            mix_g(2, 7,  8, 13, msg_block[sg[12]], msg_block[sg[13]]);
            mix_g(3, 4,  9, 14, msg_block[sg[14]], msg_block[sg[15]]);
        end
        for (int i = 0; i < 8; i++) hash_chain[i] ^= mix_v[i] ^ mix_v[i + 8];
    endtask

    // absorb one accepted word; on the final word queue the digest words
    task automatic absorb_word(input logic [63:0] w, input logic [3:0] cnt, input logic fin,
                               input bit has_ref, input logic [63:0] ref_w0);
        int n;
        int dl;
        int nw;
        digest_word_t d;
        n = (cnt > 4'd8) ? 8 : int'(cnt);
        for (int i = 0; i < n; i++) begin
            if (block_fill >= b2b_pkg::BLOCK_BYTES) begin
                add_count(64'(b2b_pkg::BLOCK_BYTES));
                compress(1'b0);
                for (int k = 0; k < 16; k++) msg_block[k] = '0;
                block_fill = 0;
            end
            msg_block[block_fill / 8] |= {56'd0, w[8*i +: 8]} << (8 * (block_fill % 8));
            block_fill++;
        end
        if (fin) begin
            add_count(64'(block_fill));
            compress(1'b1);
            dl = taken_dlen();
            nw = (dl + 7) / 8;
            for (int i = 0; i < nw; i++) begin
                d.word   = (i == 0 && has_ref) ? ref_w0 : hash_chain[i];
                d.idx    = i[2:0];
                d.vbytes = (dl - 8 * i > 8) ? 4'd8 : 4'(dl - 8 * i);
                d.last   = (i + 1 == nw);
                digest_q.push_back(d);
            end
            hash_init();
        end
    endtask

    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic fin,
                             input bit has_ref, input logic [63:0] ref_w0);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= w;
        byte_count   <= cnt;
        final_word   <= fin;
        do @(posedge clk); while (in_stall);
        absorb_word(w, cnt, fin, has_ref, ref_w0);
    endtask

    task automatic wait_idle();
        if (in_valid) in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == b2b_pkg::REG_DIGEST_LENGTH) cfg_dlen = val;
        else cfg_klen = val;
        hash_init();
        @(posedge clk);
    endtask

    task automatic send_message(input int nwords);
        logic [3:0] c;
        for (int i = 0; i < nwords - 1; i++) begin
            // mostly full words; some partial or oversized counts mid-stream
            c = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            send_word({$urandom, $urandom}, c, 1'b0, 1'b0, '0);
        end
        c = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        send_word({$urandom, $urandom}, c, 1'b1, 1'b0, '0);
    endtask

    // receiver: random stall ahead of each transaction
    initial begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        digest_word_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (digest_q.size() == 0) begin
                $error("digest transaction with nothing expected");
                err_count++;
            end else begin
                e = digest_q.pop_front();
                if (digest_word !== e.word) begin
                    $error("digest_word exp %h got %h", e.word, digest_word);
                    err_count++;
                end
                if (word_index !== e.idx) begin
                    $error("word_index exp %0d got %0d", e.idx, word_index);
                    err_count++;
                end
                if (valid_bytes !== e.vbytes) begin
                    $error("valid_bytes exp %0d got %0d", e.vbytes, valid_bytes);
                    err_count++;
                end
                if (last_of_digest !== e.last) begin
                    $error("last_of_digest exp %0b got %0b", e.last, last_of_digest);
                    err_count++;
                end
            end
        end
    end

    dir_row_t dir_rows [$];

    initial begin
        int items;
        int nw;
        logic [6:0] phase_dl [7] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd20, 7'd33, 7'd64};
        logic [6:0] phase_kl [7] = '{7'd0, 7'd64, 7'd127, 7'd5, 7'd32, 7'd0, 7'd0};

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = b2b_pkg::REG_DIGEST_LENGTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        message_word = '0;
        byte_count   = '0;
        final_word   = 1'b0;
        cfg_dlen     = 7'd64;
        cfg_klen     = 7'd0;
        hash_init();

        // reset config: empty message and "abc" have known digests
        dir_rows.push_back('{64'h0, 4'd0, 1'b1, 1'b1, 64'h03590142f7026a78});
        dir_rows.push_back('{64'h636261, 4'd3, 1'b1, 1'b1, 64'h0d4d1c983fa580ba});
        // exactly one block, then an empty final word
        for (int i = 0; i < 16; i++)
            dir_rows.push_back('{64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, 1'b0, '0});
        dir_rows.push_back('{64'h0, 4'd0, 1'b1, 1'b0, '0});
        // partial word mid-stream, empty non-final word, oversized count on final
        dir_rows.push_back('{64'h0123_4567_89ab_cdef, 4'd3, 1'b0, 1'b0, '0});
        dir_rows.push_back('{64'hdead_beef_dead_beef, 4'd0, 1'b0, 1'b0, '0});
        dir_rows.push_back('{64'hffff_ffff_ffff_ffff, 4'd15, 1'b1, 1'b0, '0});
        dir_rows.push_back('{64'h8000_0000_0000_0001, 4'd8, 1'b1, 1'b0, '0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].cnt, dir_rows[i].fin,
                      dir_rows[i].has_ref, dir_rows[i].ref_w0);

        for (int p = 0; p < 7; p++) begin
            wait_idle();
            write_reg(b2b_pkg::REG_DIGEST_LENGTH, phase_dl[p]);
            write_reg(b2b_pkg::REG_KEY_LENGTH, phase_kl[p]);
            items = 0;
            while (items < 6) begin
                if (phase_kl[p] != 0) begin
                    // key block: key bytes then zeros, one full block
                    for (int k = 0; k < 16; k++) begin
                        logic [63:0] kw;
                        kw = {$urandom, $urandom};
                        for (int b = 0; b < 8; b++)
                            if (8 * k + b >= int'(phase_kl[p])) kw[8*b +: 8] = 8'h00;
                        send_word(kw, 4'd8, 1'b0, 1'b0, '0);
                    end
                    items += 16;
                end
                nw = ($urandom_range(0, 15) == 0) ? 33 : $urandom_range(1, 6);
                send_message(nw);
                items += nw;
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
